// File: rtl/core/srp_pkg.sv
// Package for the SMTP reply parser core.
// Holds the result word type, character constants and the keyword table.
// No dependencies.
package srp_pkg;

	localparam int unsigned LenWidth  = 5;
	localparam int unsigned CodeWidth = 10;

	localparam logic [LenWidth-1:0]  LenMax     = 5'd31;
	localparam logic [LenWidth-1:0]  KwLineLen  = 5'd14;
	localparam logic [LenWidth-1:0]  CodeLen    = 5'd3;
	localparam logic [LenWidth-1:0]  KwStart    = 5'd4;
	localparam logic [CodeWidth-1:0] CodeEhloOk = 10'd250;
	localparam logic [CodeWidth-1:0] CodeTemp   = 10'd400;
	localparam logic [CodeWidth-1:0] CodePerm   = 10'd500;

	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChDash  = 8'h2D;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLowA  = 8'h61;
	localparam logic [7:0] ChLowZ  = 8'h7A;
	localparam logic [7:0] CaseBit = 8'h20;

	typedef enum logic [1:0] {
		CLASS_OK   = 2'd0,
		CLASS_TEMP = 2'd1,
		CLASS_PERM = 2'd2
	} reply_class_t;

	typedef struct packed {
		logic                 pipelining_seen;
		logic                 protocol_error;
		reply_class_t         reply_class;
		logic [CodeWidth-1:0] reply_code;
	} result_t;

	typedef struct packed {
		logic step;
		logic ehlo_mode;
	} step_ctl_t;

	function automatic logic [7:0] kw_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h50; // P
			4'd1:    c = 8'h49; // I
			4'd2:    c = 8'h50; // P
			4'd3:    c = 8'h45; // E
			4'd4:    c = 8'h4C; // L
			4'd5:    c = 8'h49; // I
			4'd6:    c = 8'h4E; // N
			4'd7:    c = 8'h49; // I
			4'd8:    c = 8'h4E; // N
			4'd9:    c = 8'h47; // G
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/srp_line_state.sv
// Running line state of the SMTP reply parser and the per-byte update.
// Depends on srp_pkg.
module srp_line_state (
	input  logic               clk,
	input  logic               arst_n,
	input  srp_pkg::step_ctl_t ctl,
	input  logic [7:0]         data_byte,
	output logic               has_result,
	output srp_pkg::result_t   result
);
	import srp_pkg::*;

	logic [LenWidth-1:0]  line_length_q;
	logic                 last_was_cr_q;
	logic [CodeWidth-1:0] code_q;
	logic                 digits_valid_q;
	logic                 fourth_is_dash_q;
	logic                 kw_match_q;
	logic                 first_line_q;
	logic                 pipe_flag_q;

	logic                 is_lf;
	logic                 is_digit;
	logic [7:0]           upper;
	logic [LenWidth-1:0]  kw_off;
	logic [LenWidth-1:0]  len_eff;
	logic                 short_err;
	logic                 final_line;
	logic                 pipe_set;
	logic                 pipe_next;
	logic [CodeWidth-1:0] code_mul;

	assign is_lf    = (data_byte == ChLf);
	assign is_digit = (data_byte >= ChZero) && (data_byte <= ChNine);
	assign upper    = ((data_byte >= ChLowA) && (data_byte <= ChLowZ)) ?
		(data_byte & ~CaseBit) : data_byte;
	assign kw_off   = line_length_q - KwStart;
	assign code_mul = CodeWidth'(code_q * 10) + CodeWidth'(data_byte - ChZero);

	assign len_eff   = (last_was_cr_q && line_length_q != '0) ?
		(line_length_q - 5'd1) : line_length_q;
	assign short_err = (len_eff < CodeLen) || !digits_valid_q;
	assign pipe_set  = ctl.ehlo_mode && (code_q == CodeEhloOk) && !first_line_q &&
		(len_eff == KwLineLen) && kw_match_q;
	assign pipe_next = pipe_flag_q || (!short_err && pipe_set);
	assign final_line = (len_eff == CodeLen) || !fourth_is_dash_q;

	assign has_result = is_lf && (short_err || final_line);

	always_comb begin
		result.pipelining_seen = pipe_next;
		result.protocol_error  = short_err;
		result.reply_code      = short_err ? '0 : code_q;
		if (short_err || code_q < CodeTemp) begin
			result.reply_class = CLASS_OK;
		end else if (code_q < CodePerm) begin
			result.reply_class = CLASS_TEMP;
		end else begin
			result.reply_class = CLASS_PERM;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_length_q    <= '0;
			last_was_cr_q    <= 1'b0;
			code_q           <= '0;
			digits_valid_q   <= 1'b1;
			fourth_is_dash_q <= 1'b0;
			kw_match_q       <= 1'b1;
			first_line_q     <= 1'b1;
			pipe_flag_q      <= 1'b0;
		end else if (ctl.step) begin
			if (is_lf) begin
				line_length_q    <= '0;
				last_was_cr_q    <= 1'b0;
				code_q           <= '0;
				digits_valid_q   <= 1'b1;
				fourth_is_dash_q <= 1'b0;
				kw_match_q       <= 1'b1;
				first_line_q     <= short_err || final_line;
				pipe_flag_q      <= pipe_next;
			end else begin
				if (line_length_q < CodeLen) begin
					if (is_digit) begin
						code_q <= code_mul;
					end else begin
						digits_valid_q <= 1'b0;
					end
				end else if (line_length_q == CodeLen) begin
					fourth_is_dash_q <= (data_byte == ChDash);
				end else if (line_length_q < KwLineLen) begin
					if (upper != kw_char(kw_off[3:0])) begin
						kw_match_q <= 1'b0;
					end
				end
				if (line_length_q < LenMax) begin
					line_length_q <= line_length_q + 5'd1;
				end
				last_was_cr_q <= (data_byte == ChCr);
			end
		end
	end

endmodule

// File: rtl/core/smtp_reply_parser_core.sv
// SMTP reply code parser core: one reply byte per word in, one result per reply out.
// Path: an accepted byte is registered in byte_s1, then its result word is registered in out_q.
// Throughput: one byte per cycle; only a held result word stalls the input register.
// Reset: arst_n puts the line state at the start of a reply and clears the pipelining flag,
// ehlo_mode and both valid bits. Depends on srp_pkg and srp_line_state.
module smtp_reply_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,    // ehlo_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata      // [9:0] reply_code, [11:10] reply_class,
	                                 // [12] protocol_error, [13] pipelining_seen
);
	import srp_pkg::*;

	logic       ehlo_mode_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv_s1;
	logic       has_result;
	result_t    result;
	result_t    out_q;
	logic       out_valid_q;
	step_ctl_t  ctl;

	assign cfg_ready = 1'b1;

	assign adv_s1   = valid_s1 && (!has_result || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	assign ctl.step      = adv_s1;
	assign ctl.ehlo_mode = ehlo_mode_q;

	srp_line_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.data_byte (byte_s1),
		.has_result(has_result),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ehlo_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			ehlo_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q};

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> out_valid_q && !m_tready && has_result)
		else $error("input register stalled without a held result word");

	a_error_zero_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.protocol_error |-> out_q.reply_code == '0 &&
		out_q.reply_class == CLASS_OK)
		else $error("protocol error word carries a code");

	a_class_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !out_q.protocol_error |->
		(out_q.reply_class == CLASS_PERM) == (out_q.reply_code >= CodePerm))
		else $error("reply class does not match reply code");

	a_pipe_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && out_q.pipelining_seen ##1 m_tvalid |->
		out_q.pipelining_seen)
		else $error("pipelining flag dropped");

endmodule

// File: tb/sv/smtp_reply_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the SMTP reply parser core: watches the config, byte and result channels,
// predicts each result word from the byte stream and compares it field by field.
// Depends on srp_pkg for the result word layout and character constants.
module smtp_reply_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          err_count,
	output int          pending
);
	import srp_pkg::*;

	localparam logic [79:0] Keyword = "PIPELINING";

	logic                 ehlo_q;
	logic [LenWidth-1:0]  line_len;
	logic                 cr_last;
	logic [CodeWidth-1:0] code_acc;
	logic                 digits_ok;
	logic                 dash_seen;
	logic                 kw_ok;
	logic                 at_first;
	logic                 pipe_flag;
	result_t              reply_q[$];

	initial err_count = 0;

	task automatic restart_line();
		line_len  = '0;
		cr_last   = 1'b0;
		code_acc  = '0;
		digits_ok = 1'b1;
		dash_seen = 1'b0;
		kw_ok     = 1'b1;
	endtask

	task automatic take_byte(input logic [7:0] b);
		logic [LenWidth-1:0] len;
		logic [7:0]          up;
		result_t             res;
		if (b != ChLf) begin
			if (line_len < CodeLen) begin
				if (b >= ChZero && b <= ChNine)
					code_acc = CodeWidth'(code_acc * 10 + (b - ChZero));
				else
					digits_ok = 1'b0;
			end else if (line_len == CodeLen) begin
				dash_seen = (b == ChDash);
			end else if (line_len < KwLineLen) begin
				up = (b >= ChLowA && b <= ChLowZ) ? b - CaseBit : b;
				if (up != Keyword[79 - 8 * (line_len - KwStart) -: 8])
					kw_ok = 1'b0;
			end
			if (line_len < LenMax)
				line_len = line_len + 1'b1;
			cr_last = (b == ChCr);
			return;
		end
		len = line_len;
		if (len >= 1 && cr_last)
			len = len - 1'b1;
		if (len < CodeLen || !digits_ok) begin
			res.reply_code      = '0;
			res.reply_class     = CLASS_OK;
			res.protocol_error  = 1'b1;
			res.pipelining_seen = pipe_flag;
			reply_q.push_back(res);
			restart_line();
			at_first = 1'b1;
			return;
		end
		if (ehlo_q && code_acc == CodeEhloOk && !at_first && len == KwLineLen && kw_ok)
			pipe_flag = 1'b1;
		if (len == CodeLen || !dash_seen) begin
			res.reply_code      = code_acc;
			res.reply_class     = (code_acc >= CodePerm) ? CLASS_PERM :
			                      (code_acc >= CodeTemp) ? CLASS_TEMP : CLASS_OK;
			res.protocol_error  = 1'b0;
			res.pipelining_seen = pipe_flag;
			reply_q.push_back(res);
			restart_line();
			at_first = 1'b1;
		end else begin
			restart_line();
			at_first = 1'b0;
		end
	endtask

	task automatic check_reply(input result_t got);
		result_t want;
		if (reply_q.size() == 0) begin
			$error("unexpected result word %h", got);
			err_count++;
			return;
		end
		want = reply_q.pop_front();
		if (got.reply_code != want.reply_code) begin
			$error("reply_code: expected %0d, got %0d", want.reply_code, got.reply_code);
			err_count++;
		end
		if (got.reply_class != want.reply_class) begin
			$error("reply_class: expected %0d, got %0d", want.reply_class, got.reply_class);
			err_count++;
		end
		if (got.protocol_error != want.protocol_error) begin
			$error("protocol_error: expected %0d, got %0d", want.protocol_error,
				got.protocol_error);
			err_count++;
		end
		if (got.pipelining_seen != want.pipelining_seen) begin
			$error("pipelining_seen: expected %0d, got %0d", want.pipelining_seen,
				got.pipelining_seen);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ehlo_q = 1'b0;
			restart_line();
			at_first  = 1'b1;
			pipe_flag = 1'b0;
			reply_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				ehlo_q = cfg_data;
			if (m_tvalid && m_tready)
				check_reply(result_t'(m_tdata[13:0]));
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
			pending <= reply_q.size();
		end
	end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the SMTP reply parser testbench: clock, reset, reply byte streams and back-pressure.
// Depends on srp_pkg, smtp_reply_parser_core and smtp_reply_checker.
module tb;
	import srp_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data  = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	int          err_count;
	int          pending;

	logic [7:0] stream_q[$];
	bit         tx_steady = 1'b0;
	bit         rx_steady = 1'b0;
	bit         hold_req  = 1'b0;
	int         hold_left = 0;
	int         rx_pick;

	smtp_reply_parser_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	smtp_reply_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.err_count (err_count),
		.pending   (pending)
	);

	always #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// The receiver holds off for a long stretch on request so that the core fills up.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 3)
				hold_left = $urandom_range(10, 50);
			m_tready <= (rx_pick >= 25);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (tx_steady || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_stream();
		int gap;
		while (stream_q.size() > 0) begin
			gap = pick_gap();
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= stream_q.pop_front();
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic add_text(input string s);
		foreach (s[i])
			stream_q.push_back(s[i]);
	endtask

	task automatic add_code(input int code);
		stream_q.push_back(8'(ChZero + code / 100));
		stream_q.push_back(8'(ChZero + (code / 10) % 10));
		stream_q.push_back(8'(ChZero + code % 10));
	endtask

	task automatic add_eol();
		if ($urandom_range(0, 4) != 0)
			stream_q.push_back(ChCr);
		stream_q.push_back(ChLf);
	endtask

	task automatic add_keyword();
		string      kw;
		logic [7:0] c;
		int         variant;
		kw = "PIPELINING";
		variant = $urandom_range(0, 5);
		if (variant == 1)
			kw[$urandom_range(0, 9)] = 8'($urandom_range(8'h20, 8'h7E));
		foreach (kw[i]) begin
			c = kw[i];
			if (variant == 4 && i == 9)
				break;
			if (c >= "A" && c <= "Z" && $urandom_range(0, 1))
				c = c + CaseBit;
			stream_q.push_back(c);
		end
		if (variant == 3)
			stream_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
	endtask

	task automatic add_random_text();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
		repeat (n) stream_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
	endtask

	function automatic int pick_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 250;
		if (r < 70)
			return $urandom_range(400, 599);
		return $urandom_range(0, 999);
	endfunction

	task automatic add_reply();
		int         kind;
		int         lines;
		int         code;
		int         bad;
		logic [7:0] c;
		kind = $urandom_range(0, 99);
		if (kind < 72) begin
			lines = $urandom_range(1, 4);
			code  = pick_code();
			for (int i = 0; i < lines; i++) begin
				add_code(($urandom_range(0, 9) == 0) ? pick_code() : code);
				if (i < lines - 1) begin
					stream_q.push_back(ChDash);
				end else if ($urandom_range(0, 3) == 0) begin
					add_eol();
					continue;
				end else begin
					stream_q.push_back(" ");
				end
				if ($urandom_range(0, 9) < 4)
					add_keyword();
				else
					add_random_text();
				add_eol();
			end
		end else if (kind < 86) begin
			repeat ($urandom_range(0, 8)) stream_q.push_back(8'($urandom_range(0, 255)));
			stream_q.push_back(ChLf);
		end else if (kind < 93) begin
			bad = $urandom_range(0, 2);
			for (int i = 0; i < 3; i++) begin
				c = 8'($urandom_range(ChZero, ChNine));
				if (i == bad) begin
					c = 8'($urandom_range(0, 255));
					if (c >= ChZero && c <= ChNine)
						c = $urandom_range(0, 1) ? 8'(ChZero - 8'd1) : 8'(ChNine + 8'd1);
				end
				stream_q.push_back(c);
			end
			add_random_text();
			add_eol();
		end else begin
			repeat ($urandom_range(0, 2))
				stream_q.push_back(8'($urandom_range(ChZero, ChNine)));
			add_eol();
		end
	endtask

	initial begin
		logic mode_seq[6];
		mode_seq = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// Directed: empty line, CR strip at code 999, 0xFF in the code, CR as an ordinary
		// character, a continuation line, then a short line holding 0x00.
		write_mode(1'b0);
		add_text("\n999\x0D\n4");
		stream_q.push_back(8'hFF);
		add_text("0\n000\x0D\x0D\n100-\n");
		stream_q.push_back(8'h00);
		add_text("\n");
		send_stream();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			write_mode(mode_seq[ph]);
			rx_steady = (ph == 2);
			tx_steady = (ph == 3);
			while (stream_q.size() < 170)
				add_reply();
			send_stream();
			drain();
		end
		rx_steady = 1'b0;
		tx_steady = 1'b0;

		// Back-to-back short replies against a long receiver hold-off.
		write_mode(1'b0);
		hold_req = 1'b1;
		tx_steady = 1'b1;
		repeat (30) begin
			add_code(pick_code());
			add_eol();
		end
		send_stream();
		drain();

		if (err_count == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/srp_pkg.sv
rtl/core/srp_line_state.sv
rtl/core/smtp_reply_parser_core.sv
tb/sv/smtp_reply_checker.sv
tb/sv/tb.sv
